### rtl/rdc_pkg.sv
// Shared constants and controller/datapath interface types for the radix digit converter.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

   // Default sizing
   localparam int VALUE_BITS_DEF  = 31;
   localparam int STACK_DEPTH_DEF = 32;

   // Digit and radix register width
   localparam int DIGIT_W = 6;

   // Quotient bits retired by the divider per clock
   localparam int DIV_BITS = 8;

   // Radix register reset value and smallest usable radix
   localparam logic [DIGIT_W-1:0] RADIX_RESET = 6'd8;
   localparam logic [DIGIT_W-1:0] RADIX_MIN   = 6'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // take a new value, clear stack
      logic div_step;  // one divider step
      logic push;      // push remainder, restart divider on quotient
      logic pop;       // read top of stack into output register
   } rdc_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic quot_zero;  // quotient register holds zero
      logic last;       // output register holds the final digit
   } rdc_stat_type;

endpackage

`default_nettype wire

### rtl/rdc_datapath.sv
// Datapath: radix register, multi-bit restoring divider, digit stack and output register.
`timescale 1ns / 1ps
`default_nettype none

module rdc_datapath #(
   parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
   parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wen,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]  csr_wdata,
   input  wire logic [VALUE_BITS-1:0]        value,
   input  wire rdc_pkg::rdc_cmd_type         cmd,
   output rdc_pkg::rdc_stat_type             stat,
   output logic [rdc_pkg::DIGIT_W-1:0]       digit
);

   localparam int DW     = rdc_pkg::DIGIT_W;
   localparam int DIV_W  = ((VALUE_BITS + rdc_pkg::DIV_BITS - 1) / rdc_pkg::DIV_BITS)
                           * rdc_pkg::DIV_BITS;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [DW-1:0]     radix_ff;
   logic [DW-1:0]     radix_eff;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_dec;
   logic [DW-1:0]     digit_ff;
   logic              last_ff;
   logic [DW-1:0]     stack_mem [STACK_DEPTH];

   // Radix register; 0 and 1 divide as 2
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= rdc_pkg::RADIX_RESET;
      end else if (csr_wen) begin
         radix_ff <= csr_wdata;
      end
   end

   assign radix_eff = (radix_ff < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN : radix_ff;

   // One divider step: shift DIV_BITS dividend bits through the partial remainder
   always_comb begin
      logic [DIV_W-1:0] q;
      logic [DW:0]      r;
      q = quot_ff;
      r = {1'b0, rem_ff};
      for (int i = 0; i < rdc_pkg::DIV_BITS; i++) begin
         r = {r[DW-1:0], q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, radix_eff}) begin
            r    = r - {1'b0, radix_eff};
            q[0] = 1'b1;
         end
      end
      quot_in = q;
      rem_in  = r[DW-1:0];
   end

   assign count_dec = count_ff - CNT_W'(1);

   // Divider registers and stack pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= '0;
      end else if (cmd.push && (count_ff < CNT_W'(STACK_DEPTH))) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_ff <= count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= DIV_W'(value);
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end else if (cmd.push) begin
         rem_ff  <= '0;
      end
   end

   // Digit stack: remainders pushed low digit first; surplus high digits dropped
   always_ff @(posedge clock) begin
      if (cmd.push && (count_ff < CNT_W'(STACK_DEPTH))) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= rem_ff;
      end
      if (cmd.pop) begin
         digit_ff <= stack_mem[count_dec[ADDR_W-1:0]];
         last_ff  <= (count_ff == CNT_W'(1));
      end
   end

   assign digit          = digit_ff;
   assign stat.quot_zero = (quot_ff == '0);
   assign stat.last      = last_ff;

endmodule

`default_nettype wire

### rtl/rdc_controller.sv
// Controller: sequences load, divide, push, pop and output handshake.
`timescale 1ns / 1ps
`default_nettype none

module rdc_controller #(
   parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire rdc_pkg::rdc_stat_type stat,
   output rdc_pkg::rdc_cmd_type       cmd
);

   localparam int DIV_CYCLES = (VALUE_BITS + rdc_pkg::DIV_BITS - 1) / rdc_pkg::DIV_BITS;
   localparam int STEP_W     = $clog2(DIV_CYCLES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUSH,
      ST_READ,
      ST_SEND
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              last_step;

   assign last_step = (step_ff == STEP_W'(DIV_CYCLES - 1));

   // State register and divider step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               step_ff <= '0;
               if (req_tvalid) begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + STEP_W'(1);
               if (last_step) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               step_ff <= '0;
               // quotient zero: all digits are on the stack
               state_ff <= stat.quot_zero ? ST_READ : ST_DIVIDE;
            end
            ST_READ: begin
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (rsp_tready) begin
                  state_ff <= stat.last ? ST_IDLE : ST_READ;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Handshake and datapath commands decoded from state
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      rsp_tvalid   = (state_ff == ST_SEND);
      cmd.load     = (state_ff == ST_IDLE) && req_tvalid;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.push     = (state_ff == ST_PUSH);
      cmd.pop      = (state_ff == ST_READ);
   end

endmodule

`default_nettype wire

### rtl/radix_digit_converter_top.sv
// Top level of the radix digit converter: controller, datapath and checks.
//
// Usage:
//   csr_wen/csr_wdata write the radix (reset 8; 0 and 1 act as 2). Write it
//   only while the block is idle.
//   The req_ channel takes one value per beat. For each value the rsp_
//   channel returns one beat per digit, most significant first; rsp_tlast
//   marks the least significant digit. Zero gives the single digit 0.
//   Timing: the divider retires 8 quotient bits a clock. Each digit comes
//   from the divide steps and a push onto the stack; the stack is then
//   read one digit at a time, and each digit is offered on rsp_ until
//   rsp_tready takes it. One value is worked on at a time; req_tready is
//   high only while idle.
//   Reset returns the controller to idle, empties the stack and sets the
//   radix to 8. When the receiver stalls, the current digit is held on
//   rsp_tdata/rsp_tlast until taken and no new value is accepted.
`timescale 1ns / 1ps
`default_nettype none

module radix_digit_converter_top #(
   parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF,
   parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wen,
   input  wire logic [rdc_pkg::DIGIT_W-1:0]          csr_wdata,   // radix
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [((VALUE_BITS+7)/8)*8-1:0]      req_tdata,   // value, zero pad
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [7:0]                                rsp_tdata,   // digit, zero pad
   output logic                                      rsp_tlast    // last_digit
);

   rdc_pkg::rdc_cmd_type             cmd;
   rdc_pkg::rdc_stat_type            stat;
   logic [rdc_pkg::DIGIT_W-1:0]      digit;

   rdc_controller #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rdc_datapath #(
      .VALUE_BITS  (VALUE_BITS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .value     (req_tdata[VALUE_BITS-1:0]),
      .cmd       (cmd),
      .stat      (stat),
      .digit     (digit)
   );

   assign rsp_tdata = 8'(digit);
   assign rsp_tlast = stat.last;

   // Never take a new value while a digit is still on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while result pending");

   // A non-final digit handed over is followed by a stack read cycle
   a_pop_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (!rsp_tvalid && !req_tready))
      else $error("no stack read between digits");

   // The final digit returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("not idle after last digit");

   // An accepted value produces no digit in the next cycle
   a_divide_first: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("digit before division");

endmodule

`default_nettype wire
